// ----- hw/rtl/opwe_pkg.sv -----
package opwe_pkg;

  localparam int CODE_W  = 24;
  localparam int BLEN_W  = 5;
  localparam int TUNIT_W = 16;
  localparam int GUARD_W = 7;
  localparam int DUR_W   = 23;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W  = 3;

  localparam logic [GUARD_W-1:0] GUARD_MIN = 7'd15;
  localparam logic [GUARD_W-1:0] GUARD_MAX = 7'd72;
  localparam logic [GUARD_W-1:0] MULT_ONE  = 7'd1;
  localparam logic [GUARD_W-1:0] MULT_LONG = 7'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CODE_WORD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_LENGTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_UNIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_UNITS = 3'd3;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_TEST  = 3'd1;
  localparam step_t STEP_BITHI = 3'd2;
  localparam step_t STEP_BITLO = 3'd3;
  localparam step_t STEP_STOP  = 3'd4;
  localparam step_t STEP_GUARD = 3'd5;

  // sequencing of one microstep
  typedef enum logic [1:0] {
    SQ_NEXT,      // advance (after the segment is taken, if any)
    SQ_JUMP,      // go to target (after the segment is taken, if any)
    SQ_WAIT_REQ,  // hold until an input transfer with frame_request set
    SQ_TEST_CNT   // bits left: pop one and advance; none: go to target
  } seq_t;

  typedef enum logic [1:0] {
    MS_ONE,
    MS_BIT_LONG,   // 3 for a one bit, else 1
    MS_BIT_SHORT,  // 1 for a one bit, else 3
    MS_GUARD
  } mult_sel_t;

  typedef struct packed {
    logic      emit;
    logic      level;
    mult_sel_t mult;
    logic      last;
    seq_t      seq;
    step_t     target;
  } uword_t;

  typedef struct packed {
    logic load;   // start frame: load bit counter
    logic pop;    // take next code bit
    logic emit;   // write a segment to the output register
  } act_t;

  typedef struct packed {
    logic cnt_zero;
    logic slot_free;
  } dp_stat_t;

endpackage

// ----- hw/rtl/opwe_urom.sv -----
module opwe_urom
  import opwe_pkg::*;
(
  input  step_t  step,
  output uword_t uword
);

  always_comb begin
    uword = '{emit: 1'b0, level: 1'b0, mult: MS_ONE, last: 1'b0,
              seq: SQ_JUMP, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        uword.seq = SQ_WAIT_REQ;
      end
      STEP_TEST: begin
        uword.seq    = SQ_TEST_CNT;
        uword.target = STEP_STOP;
      end
      STEP_BITHI: begin
        uword.emit  = 1'b1;
        uword.level = 1'b1;
        uword.mult  = MS_BIT_LONG;
        uword.seq   = SQ_NEXT;
      end
      STEP_BITLO: begin
        uword.emit   = 1'b1;
        uword.mult   = MS_BIT_SHORT;
        uword.target = STEP_TEST;
      end
      STEP_STOP: begin
        uword.emit  = 1'b1;
        uword.level = 1'b1;
        uword.seq   = SQ_NEXT;
      end
      STEP_GUARD: begin
        uword.emit = 1'b1;
        uword.mult = MS_GUARD;
        uword.last = 1'b1;
      end
      default: begin
        uword.target = STEP_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/opwe_seq.sv -----
module opwe_seq
  import opwe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  uword_t   uword,
  input  dp_stat_t stat,
  input  logic     in_valid,
  input  logic     in_frame_request,
  output logic     in_ready,
  output step_t    step,
  output act_t     act
);

  step_t step_r, step_nxt;

  assign step     = step_r;
  assign in_ready = (uword.seq == SQ_WAIT_REQ);

  always_comb begin
    step_nxt = step_r;
    act      = '0;
    case (uword.seq)
      SQ_WAIT_REQ: begin
        if (in_valid && in_frame_request) begin
          act.load = 1'b1;
          step_nxt = step_r + 1'b1;
        end
      end
      SQ_TEST_CNT: begin
        if (stat.cnt_zero) begin
          step_nxt = uword.target;
        end else begin
          act.pop  = 1'b1;
          step_nxt = step_r + 1'b1;
        end
      end
      SQ_NEXT, SQ_JUMP: begin
        if (!uword.emit || stat.slot_free) begin
          act.emit = uword.emit;
          step_nxt = (uword.seq == SQ_JUMP) ? uword.target : step_r + 1'b1;
        end
      end
      default: begin
        step_nxt = STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ----- hw/rtl/opwe_dp.sv -----
module opwe_dp
  import opwe_pkg::*;
#(
  parameter int MAX_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_data,
  input  uword_t               uword,
  input  act_t                 act,
  output dp_stat_t             stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_pulse_level,
  output logic [DUR_W-1:0]     out_pulse_duration,
  output logic                 out_frame_last
);

  localparam int CNT_W = $clog2(MAX_BITS + 1);
  localparam logic [BLEN_W-1:0] MAX_LEN = BLEN_W'(MAX_BITS);

  logic [CODE_W-1:0]  code_word_r;
  logic [BLEN_W-1:0]  bit_length_r;
  logic [TUNIT_W-1:0] time_unit_r;
  logic [GUARD_W-1:0] guard_units_r;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               bit_r, bit_nxt;
  logic [CNT_W-1:0]   pos;
  logic [CODE_W-1:0]  shifted;
  logic [BLEN_W-1:0]  len_sat;
  logic [GUARD_W-1:0] mult;

  logic               out_valid_r;
  logic               level_r;
  logic [DUR_W-1:0]   dur_r;
  logic               last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_word_r   <= '0;
      bit_length_r  <= 5'd24;
      time_unit_r   <= 16'd400;
      guard_units_r <= 7'd30;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CODE_WORD:   code_word_r  <= cfg_data;
        REG_BIT_LENGTH:  bit_length_r <= cfg_data[BLEN_W-1:0];
        REG_TIME_UNIT:   time_unit_r  <= cfg_data[TUNIT_W-1:0];
        REG_GUARD_UNITS: begin
          if (cfg_data[GUARD_W-1:0] >= GUARD_MIN && cfg_data[GUARD_W-1:0] <= GUARD_MAX) begin
            guard_units_r <= cfg_data[GUARD_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // bit counter; positions past the code word shift in zeros
  assign len_sat = (bit_length_r > MAX_LEN) ? MAX_LEN : bit_length_r;
  assign pos     = cnt_r - 1'b1;
  assign shifted = code_word_r >> pos;

  always_comb begin
    cnt_nxt = cnt_r;
    bit_nxt = bit_r;
    if (act.load) begin
      cnt_nxt = CNT_W'(len_sat);
    end else if (act.pop) begin
      cnt_nxt = pos;
      bit_nxt = shifted[0];
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    bit_r <= bit_nxt;
  end

  always_comb begin
    case (uword.mult)
      MS_ONE:       mult = MULT_ONE;
      MS_BIT_LONG:  mult = bit_r ? MULT_LONG : MULT_ONE;
      MS_BIT_SHORT: mult = bit_r ? MULT_ONE : MULT_LONG;
      MS_GUARD:     mult = guard_units_r;
      default:      mult = MULT_ONE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (act.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (act.emit) begin
      level_r <= uword.level;
      dur_r   <= DUR_W'(time_unit_r * mult);
      last_r  <= uword.last;
    end
  end

  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.slot_free = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_pulse_level    = level_r;
  assign out_pulse_duration = dur_r;
  assign out_frame_last     = last_r;

endmodule

// ----- hw/rtl/ook_pulse_width_encoder.sv -----
// channel   dir  handshake             payload
// in_       in   in_valid/in_ready     in_frame_request
// out_      out  out_valid/out_ready   out_pulse_level, out_pulse_duration, out_frame_last
// cfg_      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A frame of n code bits runs these microsteps:
// one step takes the request, n + 1 steps test the bit counter, one step per segment.
// A request with frame_request low is taken and emits nothing.
// Output stalls hold the microprogram on its current segment step.
// Synchronous active-low reset; config registers return to defaults.
module ook_pulse_width_encoder
  import opwe_pkg::*;
#(
  parameter int MAX_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_frame_request,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_pulse_level,
  output logic [DUR_W-1:0]     out_pulse_duration,
  output logic                 out_frame_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_data
);

  step_t    step;
  uword_t   uword;
  act_t     act;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  opwe_urom u_urom (
    .step  (step),
    .uword (uword)
  );

  opwe_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .uword            (uword),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_frame_request (in_frame_request),
    .in_ready         (in_ready),
    .step             (step),
    .act              (act)
  );

  opwe_dp #(
    .MAX_BITS (MAX_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .uword              (uword),
    .act                (act),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pulse_level    (out_pulse_level),
    .out_pulse_duration (out_pulse_duration),
    .out_frame_last     (out_frame_last)
  );

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_frame_request |=> !in_ready)
    else $error("input taken again right after a frame request");

  a_last_is_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> !out_pulse_level)
    else $error("frame end segment not low");

  a_no_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    act.emit |-> !in_ready)
    else $error("segment written while waiting for a request");

endmodule

// ----- tb/opwe_pulse_checker.sv -----
`timescale 1ns / 1ps

module opwe_pulse_checker
  import opwe_pkg::*;
#(
  parameter int MAX_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_frame_request,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_pulse_level,
  input  logic [DUR_W-1:0]     out_pulse_duration,
  input  logic                 out_frame_last,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CODE_W-1:0]    cfg_data,
  input  logic                 finished,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] duration;
    logic             last;
  } pulse_t;

  pulse_t pulse_train_q[$];

  logic [CODE_W-1:0]  code_reg;
  logic [BLEN_W-1:0]  blen_reg;
  logic [TUNIT_W-1:0] unit_reg;
  logic [GUARD_W-1:0] guard_reg;

  int errors = 0;
  bit leftover_checked = 1'b0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic logic [DUR_W-1:0] scaled(input logic [GUARD_W-1:0] mult);
    return DUR_W'(unit_reg) * DUR_W'(mult);
  endfunction

  function automatic void push_pulse(input logic level, input logic [DUR_W-1:0] dur,
                                     input logic last);
    pulse_t p;
    p.level = level;
    p.duration = dur;
    p.last = last;
    pulse_train_q.insert(pulse_train_q.size(), p);
  endfunction

  always @(posedge clk) begin
    pulse_t got;
    pulse_t want;
    int nbits;
    logic code_bit;
    if (!rst_n) begin
      code_reg  = '0;
      blen_reg  = BLEN_W'(24);
      unit_reg  = TUNIT_W'(400);
      guard_reg = GUARD_W'(30);
      pulse_train_q.delete();
    end else begin
      // results come from earlier requests, so compare before predicting
      if (out_valid && out_ready) begin
        got.level = out_pulse_level;
        got.duration = out_pulse_duration;
        got.last = out_frame_last;
        if (pulse_train_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected pulse level=%0d dur=%0d last=%0d", $time,
                     got.level, got.duration, got.last);
        end else begin
          want = pulse_train_q.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: pulse mismatch exp level=%0d dur=%0d last=%0d, ",
                        "got level=%0d dur=%0d last=%0d"},
                       $time, want.level, want.duration, want.last,
                       got.level, got.duration, got.last);
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CODE_WORD:   code_reg = cfg_data;
          REG_BIT_LENGTH:  blen_reg = cfg_data[BLEN_W-1:0];
          REG_TIME_UNIT:   unit_reg = cfg_data[TUNIT_W-1:0];
          REG_GUARD_UNITS: begin
            // out-of-range guard writes leave the register alone
            if (cfg_data[GUARD_W-1:0] >= GUARD_MIN && cfg_data[GUARD_W-1:0] <= GUARD_MAX)
              guard_reg = cfg_data[GUARD_W-1:0];
          end
          default: ;
        endcase
      end

      if (in_valid && in_ready && in_frame_request) begin
        nbits = (int'(blen_reg) > MAX_BITS) ? MAX_BITS : int'(blen_reg);
        for (int i = nbits - 1; i >= 0; i--) begin
          code_bit = (i < CODE_W) ? code_reg[i] : 1'b0;
          if (code_bit) begin
            push_pulse(1'b1, scaled(MULT_LONG), 1'b0);
            push_pulse(1'b0, scaled(MULT_ONE), 1'b0);
          end else begin
            push_pulse(1'b1, scaled(MULT_ONE), 1'b0);
            push_pulse(1'b0, scaled(MULT_LONG), 1'b0);
          end
        end
        push_pulse(1'b1, scaled(MULT_ONE), 1'b0);
        push_pulse(1'b0, scaled(guard_reg), 1'b1);
      end
    end

    if (finished && !leftover_checked) begin
      leftover_checked = 1'b1;
      if (pulse_train_q.size() != 0) begin
        errors += pulse_train_q.size();
        $display("%0t: %0d expected pulses never arrived", $time, pulse_train_q.size());
      end
    end

    pending = pulse_train_q.size();
    fail_count = errors;
  end

endmodule

// ----- tb/ook_pulse_width_encoder_tb.sv -----
`timescale 1ns / 1ps

module ook_pulse_width_encoder_tb;
  import opwe_pkg::*;

  localparam int MAX_BITS     = 24;
  localparam int RESET_CYCLES = 10;
  localparam int TARGET_ITEMS = 370;
  localparam int IDLE_SETTLE  = 8;
  localparam int END_SETTLE   = 20;
  localparam int HOLD_CYCLES  = 500;
  localparam int HOLD_AFTER   = 120;
  localparam int CYCLE_LIMIT  = 3_000_000;

  // indexes past the register list
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_frame_request = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_pulse_level;
  logic [DUR_W-1:0]     out_pulse_duration;
  logic                 out_frame_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CODE_W-1:0]    cfg_data = '0;

  logic finished = 1'b0;
  logic hold_out = 1'b0;
  bit   calm = 1'b0;
  int   items_sent = 0;
  int   fail_count;
  int   pending;
  int   ready_gap = 0;
  int   cycle_count = 0;

  always #5 clk = ~clk;

  ook_pulse_width_encoder #(.MAX_BITS(MAX_BITS)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_frame_request  (in_frame_request),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pulse_level   (out_pulse_level),
    .out_pulse_duration(out_pulse_duration),
    .out_frame_last    (out_frame_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  opwe_pulse_checker #(.MAX_BITS(MAX_BITS)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_frame_request  (in_frame_request),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pulse_level   (out_pulse_level),
    .out_pulse_duration(out_pulse_duration),
    .out_frame_last    (out_frame_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .finished          (finished),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random back-pressure, plus the long hold-off below
  always @(negedge clk) begin
    if (hold_out) begin
      out_ready <= 1'b0;
    end else if (ready_gap > 0) begin
      out_ready <= 1'b0;
      ready_gap--;
    end else begin
      out_ready <= 1'b1;
      ready_gap = calm ? 0 : pick_gap();
    end
  end

  // hold the result side off while requests keep coming, so the input stalls
  initial begin
    wait (items_sent >= HOLD_AFTER);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ook_pulse_width_encoder_tb NOT OK");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_request(input logic req);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_frame_request <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CODE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // drop valid, drain all pulses, then give a trailing empty request time to retire
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  initial begin
    int phase;
    int nitems;
    int r;
    logic [GUARD_W-1:0] g;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    wait_idle();

    // widest code, longest durations
    cfg_write(REG_CODE_WORD, 24'hFFFFFF);
    cfg_write(REG_BIT_LENGTH, 24'd24);
    cfg_write(REG_TIME_UNIT, 24'd65535);
    cfg_write(REG_GUARD_UNITS, 24'd72);
    send_request(1'b1);
    send_request(1'b1);
    wait_idle();

    // no code bits, zero time unit, shortest guard
    cfg_write(REG_BIT_LENGTH, 24'd0);
    cfg_write(REG_TIME_UNIT, 24'd0);
    cfg_write(REG_GUARD_UNITS, 24'd15);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    wait_idle();

    // length saturates; bad guard values and unknown indexes change nothing
    cfg_write(REG_BIT_LENGTH, 24'd31);
    cfg_write(REG_CODE_WORD, 24'hA5A5A5);
    cfg_write(REG_TIME_UNIT, 24'd1);
    cfg_write(REG_GUARD_UNITS, 24'd14);
    cfg_write(REG_GUARD_UNITS, 24'd73);
    cfg_write(REG_GUARD_UNITS, 24'd127);
    cfg_write(REG_GUARD_UNITS, 24'd0);
    for (int i = REG_UNUSED_LO; i <= REG_UNUSED_HI; i++)
      cfg_write(CFG_IDX_W'(i), 24'hFFFFFF);
    send_request(1'b1);
    wait_idle();

    // single bit; upper data bits beyond each register are dropped
    cfg_write(REG_BIT_LENGTH, 24'hFFFFE1);
    cfg_write(REG_CODE_WORD, 24'h000001);
    cfg_write(REG_TIME_UNIT, 24'hFF0003);
    cfg_write(REG_GUARD_UNITS, 24'hFFFFA8);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);
    wait_idle();

    cfg_write(REG_BIT_LENGTH, 24'd25);
    cfg_write(REG_CODE_WORD, 24'h800000);
    send_request(1'b1);
    wait_idle();

    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 3) != 0)
        cfg_write(REG_CODE_WORD, CODE_W'($urandom));
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 99);
        if (r < 60) cfg_write(REG_BIT_LENGTH, CODE_W'($urandom_range(1, 6)));
        else if (r < 75) cfg_write(REG_BIT_LENGTH, CODE_W'($urandom_range(7, 23)));
        else if (r < 85) cfg_write(REG_BIT_LENGTH, 24'd24);
        else if (r < 92) cfg_write(REG_BIT_LENGTH, CODE_W'($urandom_range(25, 31)));
        else cfg_write(REG_BIT_LENGTH, 24'd0);
      end
      if ($urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 99);
        if (r < 10) cfg_write(REG_TIME_UNIT, 24'd0);
        else if (r < 20) cfg_write(REG_TIME_UNIT, 24'd65535);
        else if (r < 50) cfg_write(REG_TIME_UNIT, CODE_W'($urandom));
        else cfg_write(REG_TIME_UNIT, CODE_W'($urandom_range(1, 1000)));
      end
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 99) < 70)
          g = GUARD_W'($urandom_range(int'(GUARD_MIN), int'(GUARD_MAX)));
        else
          g = GUARD_W'($urandom);
        cfg_write(REG_GUARD_UNITS, (CODE_W'($urandom) & 24'hFFFF80) | CODE_W'(g));
      end
      if ($urandom_range(0, 9) == 0)
        cfg_write(CFG_IDX_W'($urandom_range(int'(REG_UNUSED_LO), int'(REG_UNUSED_HI))),
                  CODE_W'($urandom));

      calm = (phase % 4 == 1);
      nitems = $urandom_range(5, 30);
      repeat (nitems) send_request($urandom_range(0, 99) < 80);
      wait_idle();
      calm = 1'b0;
      phase++;
    end

    repeat (END_SETTLE) @(negedge clk);
    finished <= 1'b1;
    repeat (3) @(negedge clk);
    if (fail_count == 0)
      $display("ook_pulse_width_encoder_tb OK");
    else
      $display("ook_pulse_width_encoder_tb NOT OK");
    $finish;
  end

endmodule
